### rtl/tfm_pkg.sv
// Shared constants and width helpers for the temporal frame mean block.
`default_nettype none

package tfm_pkg;

   localparam int CHAN_W        = 8;
   localparam int CHANNELS      = 3;
   localparam int PIX_W         = CHAN_W * CHANNELS;
   localparam int ADDR_W        = 16;
   localparam int FRAME_PIXELS  = 65536;
   localparam int WIN_W         = 4;
   localparam int MAX_WINDOW    = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int CSR_AW        = 3;
   localparam int CSR_DW        = 32;
   localparam int BACK_STAGES   = 4;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd7;

   // Register index, taken from the word address bit of the CSR port.
   localparam logic REG_WINDOW_LENGTH = 1'b0;

   function automatic int slot_width(input int m);
      return (m > 1) ? $clog2(m) : 1;
   endfunction

   function automatic int count_width(input int m);
      return $clog2(m + 1);
   endfunction

   function automatic int item_width(input int m);
      return ADDR_W + PIX_W + 1 + slot_width(m) + count_width(m);
   endfunction

endpackage

`default_nettype wire

### rtl/tfm_front.sv
// Front end: CSR window register, frame bookkeeping, item classification.
`default_nettype none

module tfm_front #(
   parameter int MAX_WINDOW = tfm_pkg::MAX_WINDOW,
   localparam int SLOT_W = tfm_pkg::slot_width(MAX_WINDOW),
   localparam int CNT_W  = tfm_pkg::count_width(MAX_WINDOW),
   localparam int ITEM_W = tfm_pkg::item_width(MAX_WINDOW)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [tfm_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [tfm_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [tfm_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tfm_pkg::ADDR_W-1:0]    req_pixel_addr,
   input  wire logic [tfm_pkg::CHAN_W-1:0]    req_chan0,
   input  wire logic [tfm_pkg::CHAN_W-1:0]    req_chan1,
   input  wire logic [tfm_pkg::CHAN_W-1:0]    req_chan2,
   input  wire logic                          req_frame_end,
   output logic                               push,
   output logic      [ITEM_W-1:0]             push_item,
   input  wire logic                          queue_full
);

   localparam int CMP_W = ((CNT_W > tfm_pkg::WIN_W) ? CNT_W : tfm_pkg::WIN_W) + 1;

   typedef struct packed {
      logic [tfm_pkg::ADDR_W-1:0] addr;
      logic [tfm_pkg::PIX_W-1:0]  pix;
      logic                       fend;
      logic [SLOT_W-1:0]          slot;
      logic [CNT_W-1:0]           count;
   } item_type;

   logic [tfm_pkg::WIN_W-1:0] window_ff, window_in;
   logic [CNT_W-1:0]          frames_seen_ff, frames_seen_in;
   logic [SLOT_W-1:0]         ring_slot_ff, ring_slot_in;
   logic                      csr_write;
   logic [CMP_W-1:0]          win_eff;
   logic [CMP_W-1:0]          seen_plus;
   logic [CMP_W-1:0]          count_sel;
   item_type                  item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == tfm_pkg::REG_WINDOW_LENGTH);
   assign csr_prdata = (csr_paddr[2] == tfm_pkg::REG_WINDOW_LENGTH)
                       ? tfm_pkg::CSR_DW'(window_ff) : '0;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Clamp the window to 1..MAX_WINDOW, then limit by frames available.
   always_comb begin
      if (window_ff == '0) begin
         win_eff = CMP_W'(1);
      end else if (CMP_W'(window_ff) > CMP_W'(MAX_WINDOW)) begin
         win_eff = CMP_W'(MAX_WINDOW);
      end else begin
         win_eff = CMP_W'(window_ff);
      end
      seen_plus = CMP_W'(frames_seen_ff) + CMP_W'(1);
      count_sel = (seen_plus > win_eff) ? win_eff : seen_plus;
   end

   always_comb begin
      item.addr  = req_pixel_addr;
      item.pix   = {req_chan2, req_chan1, req_chan0};
      item.fend  = req_frame_end;
      item.slot  = ring_slot_ff;
      item.count = CNT_W'(count_sel);
   end

   assign push_item = item;

   always_comb begin
      window_in      = window_ff;
      frames_seen_in = frames_seen_ff;
      ring_slot_in   = ring_slot_ff;
      if (csr_write) begin
         window_in = csr_pwdata[tfm_pkg::WIN_W-1:0];
      end
      if (push && req_frame_end) begin
         ring_slot_in = (ring_slot_ff == SLOT_W'(MAX_WINDOW - 1))
                        ? '0 : ring_slot_ff + SLOT_W'(1);
         if (frames_seen_ff != CNT_W'(MAX_WINDOW)) begin
            frames_seen_in = frames_seen_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= tfm_pkg::WINDOW_RESET;
         frames_seen_ff <= '0;
         ring_slot_ff   <= '0;
      end else begin
         window_ff      <= window_in;
         frames_seen_ff <= frames_seen_in;
         ring_slot_ff   <= ring_slot_in;
      end
   end

endmodule

`default_nettype wire

### rtl/tfm_queue.sv
// Short FIFO between the front end and the back end.
`default_nettype none

module tfm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tfm_pkg::QUEUE_DEPTH,
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int FILL_W = $clog2(DEPTH + 1)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0]  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   assign full     = (fill_ff == FILL_W'(DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   fill_in = fill_ff + FILL_W'(1);
         2'b01:   fill_in = fill_ff - FILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### rtl/tfm_back.sv
// Back end: frame ring banks, per-pixel sum, rounded division, output register.
`default_nettype none

module tfm_back #(
   parameter int MAX_WINDOW = tfm_pkg::MAX_WINDOW,
   localparam int SLOT_W = tfm_pkg::slot_width(MAX_WINDOW),
   localparam int CNT_W  = tfm_pkg::count_width(MAX_WINDOW),
   localparam int ITEM_W = tfm_pkg::item_width(MAX_WINDOW)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   output logic                            pop,
   input  wire logic [ITEM_W-1:0]          head_item,
   input  wire logic                       queue_empty,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic      [tfm_pkg::CHAN_W-1:0] rsp_mean0,
   output logic      [tfm_pkg::CHAN_W-1:0] rsp_mean1,
   output logic      [tfm_pkg::CHAN_W-1:0] rsp_mean2,
   output logic                            rsp_frame_done
);

   localparam int CHAN_W  = tfm_pkg::CHAN_W;
   localparam int NCH     = tfm_pkg::CHANNELS;
   localparam int SUM_W   = $clog2((2 ** CHAN_W - 1) * MAX_WINDOW + 1);
   localparam int SHIFT   = SUM_W + CNT_W;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;

   typedef struct packed {
      logic [tfm_pkg::ADDR_W-1:0] addr;
      logic [tfm_pkg::PIX_W-1:0]  pix;
      logic                       fend;
      logic [SLOT_W-1:0]          slot;
      logic [CNT_W-1:0]           count;
   } item_type;

   item_type                  head;
   logic                      advance;

   // stage 1: ring read data plus item
   logic                      s1_valid_ff, s1_valid_in;
   logic [tfm_pkg::PIX_W-1:0] s1_pix_ff;
   logic [SLOT_W-1:0]         s1_slot_ff;
   logic [CNT_W-1:0]          s1_count_ff;
   logic                      s1_fend_ff;
   logic [tfm_pkg::PIX_W-1:0] rd_ff [MAX_WINDOW];
   logic [SUM_W-1:0]          s2_sum_in [NCH];

   // stage 2: channel sums
   logic                      s2_valid_ff;
   logic [SUM_W-1:0]          s2_sum_ff [NCH];
   logic [CNT_W-1:0]          s2_count_ff;
   logic                      s2_fend_ff;
   logic [RECIP_W-1:0]        recip_tab [MAX_WINDOW];
   logic [RECIP_W-1:0]        recip;
   logic [SUM_W-1:0]          s3_quot_in [NCH];

   // stage 3: truncated quotients
   logic                      s3_valid_ff;
   logic [SUM_W-1:0]          s3_quot_ff [NCH];
   logic [SUM_W-1:0]          s3_sum_ff [NCH];
   logic [CNT_W-1:0]          s3_count_ff;
   logic                      s3_fend_ff;
   logic [CHAN_W-1:0]         mean_in [NCH];

   // output register
   logic                      rsp_valid_ff;
   logic [CHAN_W-1:0]         mean_ff [NCH];
   logic                      fend_ff;

   assign head    = head_item;
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !queue_empty;
   assign s1_valid_in = pop;

   // One bank per ring slot: the current slot is written, every bank is read.
   for (genvar b = 0; b < MAX_WINDOW; b++) begin : g_bank
      logic [tfm_pkg::PIX_W-1:0] bank_mem [tfm_pkg::FRAME_PIXELS];

      always_ff @(posedge clock) begin
         if (pop && (head.slot == SLOT_W'(b))) begin
            bank_mem[head.addr] <= head.pix;
         end
         if (advance) begin
            rd_ff[b] <= bank_mem[head.addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pix_ff   <= head.pix;
         s1_slot_ff  <= head.slot;
         s1_count_ff <= head.count;
         s1_fend_ff  <= head.fend;
      end
   end

   // Own pixel plus older banks whose age lies below the count.
   always_comb begin
      logic [SLOT_W-1:0] age;
      logic              use_bank;
      for (int c = 0; c < NCH; c++) begin
         s2_sum_in[c] = SUM_W'(s1_pix_ff[c*CHAN_W +: CHAN_W]);
      end
      for (int b = 0; b < MAX_WINDOW; b++) begin
         if (s1_slot_ff >= SLOT_W'(b)) begin
            age = s1_slot_ff - SLOT_W'(b);
         end else begin
            age = SLOT_W'(int'(s1_slot_ff) + MAX_WINDOW - b);
         end
         use_bank = (age != '0) && (CNT_W'(age) < s1_count_ff);
         for (int c = 0; c < NCH; c++) begin
            if (use_bank) begin
               s2_sum_in[c] = s2_sum_in[c] + SUM_W'(rd_ff[b][c*CHAN_W +: CHAN_W]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_sum_ff   <= s2_sum_in;
         s2_count_ff <= s1_count_ff;
         s2_fend_ff  <= s1_fend_ff;
      end
   end

   // ceil(2^SHIFT / n): exact floor quotient for every sum below 2^SUM_W
   for (genvar n = 1; n <= MAX_WINDOW; n++) begin : g_recip
      localparam logic [RECIP_W-1:0] RECIP =
         RECIP_W'(((64'd1 << SHIFT) + 64'(n) - 64'd1) / 64'(n));
      assign recip_tab[n-1] = RECIP;
   end

   assign recip = recip_tab[SLOT_W'(s2_count_ff - CNT_W'(1))];

   always_comb begin
      logic [PROD_W-1:0] prod;
      for (int c = 0; c < NCH; c++) begin
         prod          = PROD_W'(s2_sum_ff[c]) * PROD_W'(recip);
         s3_quot_in[c] = prod[SHIFT +: SUM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_quot_ff  <= s3_quot_in;
         s3_sum_ff   <= s2_sum_ff;
         s3_count_ff <= s2_count_ff;
         s3_fend_ff  <= s2_fend_ff;
      end
   end

   // Remainder and round half to even.
   always_comb begin
      logic [SUM_W+CNT_W-1:0] back_mul;
      logic [SUM_W-1:0]       rem;
      logic [CNT_W:0]         twice_rem;
      logic [CNT_W:0]         cnt_ext;
      logic                   round_up;
      for (int c = 0; c < NCH; c++) begin
         back_mul  = (SUM_W+CNT_W)'(s3_quot_ff[c]) * (SUM_W+CNT_W)'(s3_count_ff);
         rem       = s3_sum_ff[c] - back_mul[SUM_W-1:0];
         twice_rem = {rem[CNT_W-1:0], 1'b0};
         cnt_ext   = {1'b0, s3_count_ff};
         round_up  = (twice_rem > cnt_ext) || ((twice_rem == cnt_ext) && s3_quot_ff[c][0]);
         mean_in[c] = CHAN_W'(s3_quot_ff[c] + SUM_W'(round_up));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mean_ff <= mean_in;
         fend_ff <= s3_fend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mean0      = mean_ff[0];
   assign rsp_mean1      = mean_ff[1];
   assign rsp_mean2      = mean_ff[2];
   assign rsp_frame_done = fend_ff;

endmodule

`default_nettype wire

### rtl/temporal_frame_mean_top.sv
// Top level of the per-pixel temporal frame mean filter.
// Item path: queue, then 4 back stages (ring read, sum, quotient, output register) to rsp_.
// Throughput: one item per cycle unless stalled, bounded by one read port per ring bank.
// Reset (synchronous, active high): window_length to 7, frame count and ring slot to 0,
// queue and pipeline emptied. The frame ring memory is not cleared; the user must
// ensure older entries are written before they are read; the block does not enforce it.
`default_nettype none

module temporal_frame_mean_top #(
   parameter int MAX_WINDOW = tfm_pkg::MAX_WINDOW
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // configuration port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [tfm_pkg::CSR_AW-1:0]    csr_paddr,
   input  wire logic [tfm_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic      [tfm_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                               csr_pready,
   // pixel items in
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tfm_pkg::ADDR_W-1:0]    req_pixel_addr,
   input  wire logic [tfm_pkg::CHAN_W-1:0]    req_chan0,
   input  wire logic [tfm_pkg::CHAN_W-1:0]    req_chan1,
   input  wire logic [tfm_pkg::CHAN_W-1:0]    req_chan2,
   input  wire logic                          req_frame_end,
   // mean items out
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [tfm_pkg::CHAN_W-1:0]    rsp_mean0,
   output logic      [tfm_pkg::CHAN_W-1:0]    rsp_mean1,
   output logic      [tfm_pkg::CHAN_W-1:0]    rsp_mean2,
   output logic                               rsp_frame_done
);

   localparam int ITEM_W = tfm_pkg::item_width(MAX_WINDOW);

   // Front to queue: the item carries its ring slot and the frame count to
   // average over, both fixed at accept time so window writes apply at once.
   logic              push;
   logic [ITEM_W-1:0] push_item;
   logic              queue_full;

   // Queue to back end
   logic              pop;
   logic [ITEM_W-1:0] head_item;
   logic              queue_empty;

   tfm_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_addr (req_pixel_addr),
      .req_chan0      (req_chan0),
      .req_chan1      (req_chan1),
      .req_chan2      (req_chan2),
      .req_frame_end  (req_frame_end),
      .push           (push),
      .push_item      (push_item),
      .queue_full     (queue_full)
   );

   // Decouples the front from back-end stalls caused by rsp_stall.
   tfm_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (tfm_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_item),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (head_item),
      .empty     (queue_empty)
   );

   // Ring write/read, sum, divide, round; whole pipeline holds on rsp_stall while rsp_valid.
   tfm_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop            (pop),
      .head_item      (head_item),
      .queue_empty    (queue_empty),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean0      (rsp_mean0),
      .rsp_mean1      (rsp_mean1),
      .rsp_mean2      (rsp_mean2),
      .rsp_frame_done (rsp_frame_done)
   );

endmodule

`default_nettype wire

### rtl/tfm_checker.sv
// Port-level checks for the temporal frame mean top, bound to the top level.
`default_nettype none

module tfm_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire logic [tfm_pkg::CHAN_W-1:0]    rsp_mean0,
   input wire logic [tfm_pkg::CHAN_W-1:0]    rsp_mean1,
   input wire logic [tfm_pkg::CHAN_W-1:0]    rsp_mean2,
   input wire logic                          rsp_frame_done
);

   localparam int MAX_INFLIGHT = tfm_pkg::QUEUE_DEPTH + tfm_pkg::BACK_STAGES;
   localparam int FLT_W        = $clog2(MAX_INFLIGHT + 2);

   logic             in_acc;
   logic             out_acc;
   logic [FLT_W-1:0] inflight_ff, inflight_in;

   assign in_acc  = req_valid && !req_stall;
   assign out_acc = rsp_valid && !rsp_stall;

   always_comb begin
      inflight_in = inflight_ff;
      case ({in_acc, out_acc})
         2'b10:   inflight_in = inflight_ff + FLT_W'(1);
         2'b01:   inflight_in = inflight_ff - FLT_W'(1);
         default: inflight_in = inflight_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mean0) && $stable(rsp_mean1)
                                 && $stable(rsp_mean2) && $stable(rsp_frame_done))
      else $error("result changed while stalled");

   // no result without an accepted item behind it
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("result with no outstanding item");

   // queue plus pipeline never holds more than it has room for
   a_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= FLT_W'(MAX_INFLIGHT))
      else $error("too many items in flight");

   // reset empties the output
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind temporal_frame_mean_top tfm_checker u_tfm_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_mean0      (rsp_mean0),
   .rsp_mean1      (rsp_mean1),
   .rsp_mean2      (rsp_mean2),
   .rsp_frame_done (rsp_frame_done)
);

`default_nettype wire

### sim/temporal_frame_mean_top_test.sv
// Self-checking testbench for the temporal frame mean filter: directed rows, then random frames.
module temporal_frame_mean_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_W     = tfm_pkg::ADDR_W;
   localparam int CHAN_W     = tfm_pkg::CHAN_W;
   localparam int PIX_W      = tfm_pkg::PIX_W;
   localparam int WIN_W      = tfm_pkg::WIN_W;
   localparam int CSR_AW     = tfm_pkg::CSR_AW;
   localparam int CSR_DW     = tfm_pkg::CSR_DW;
   localparam int MAX_WINDOW = tfm_pkg::MAX_WINDOW;
   localparam logic [WIN_W-1:0] WINDOW_RESET = tfm_pkg::WINDOW_RESET;

   // Clock, reset and run limits
   localparam int CLK_PERIOD   = 20;
   localparam int RESET_CYCLES = 11;
   // Far beyond the slowest correct run: about 1300 items, plus drains
   localparam int CYCLE_LIMIT  = 200000;
   // This tail after the last drain leaves room for any stray result
   localparam int TAIL_CYCLES  = 20;
   localparam int BLOCK_ITEMS  = 100;
   localparam int SLOT_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   // Register 0 (window_length) sits at byte address 0
   localparam logic [CSR_AW-1:0] WINDOW_LENGTH_ADDR = '0;

   // Every frame writes these addresses, so older frames always hold them
   localparam logic [ADDR_W-1:0] POOL_ADDR [4] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};

   // Window settings for the random blocks: extremes, out-of-range and middle values
   localparam logic [WIN_W-1:0] WINDOW_PLAN [12] = '{
      4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd8, 4'd1, 4'd6, 4'd4, 4'd7};

   typedef struct packed {
      logic [ADDR_W-1:0] pixel_addr;
      logic [CHAN_W-1:0] chan0;
      logic [CHAN_W-1:0] chan1;
      logic [CHAN_W-1:0] chan2;
      logic              frame_end;
   } pixel_type;

   typedef struct packed {
      logic [CHAN_W-1:0] mean0;
      logic [CHAN_W-1:0] mean1;
      logic [CHAN_W-1:0] mean2;
      logic              frame_done;
   } mean_type;

   typedef enum logic {ROW_PIXEL, ROW_WINDOW} row_kind_type;

   // One directed row: a pixel item or a window write. Where known_mean is set the
   // expected means are typed in; otherwise the predictor supplies them.
   typedef struct packed {
      row_kind_type      kind;
      logic [ADDR_W-1:0] pixel_addr;
      logic [CHAN_W-1:0] chan0;
      logic [CHAN_W-1:0] chan1;
      logic [CHAN_W-1:0] chan2;
      logic              frame_end;
      logic [WIN_W-1:0]  window;
      logic              known_mean;
      logic [CHAN_W-1:0] mean0;
      logic [CHAN_W-1:0] mean1;
      logic [CHAN_W-1:0] mean2;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [25] = '{
      // First frame after reset: the mean of one frame is the pixel itself
      '{ROW_PIXEL,  16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 1'b1, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 4'd0, 1'b1, 8'hFF, 8'hFF, 8'hFF},
      '{ROW_PIXEL,  16'h5555, 8'h01, 8'h80, 8'hFE, 1'b0, 4'd0, 1'b1, 8'h01, 8'h80, 8'hFE},
      '{ROW_PIXEL,  16'hAAAA, 8'h7F, 8'h55, 8'hAA, 1'b1, 4'd0, 1'b1, 8'h7F, 8'h55, 8'hAA},
      // Second frame, two-frame mean: ties go to the even neighbour
      '{ROW_PIXEL,  16'h0000, 8'hFF, 8'h01, 8'h03, 1'b0, 4'd0, 1'b1, 8'h80, 8'h00, 8'h02},
      '{ROW_PIXEL,  16'hFFFF, 8'h00, 8'hFE, 8'hFD, 1'b0, 4'd0, 1'b1, 8'h80, 8'hFE, 8'hFE},
      '{ROW_PIXEL,  16'h5555, 8'hC3, 8'h3C, 8'h99, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'hAAAA, 8'h00, 8'hFF, 8'h10, 1'b1, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      // Third frame: repeated address, the later pixel overwrites the earlier
      '{ROW_PIXEL,  16'h0000, 8'h10, 8'h20, 8'h30, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'h0000, 8'hF0, 8'hE0, 8'hD0, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'hFFFF, 8'h80, 8'h80, 8'h80, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'h5555, 8'hAA, 8'h55, 8'h01, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'hAAAA, 8'h12, 8'h34, 8'h56, 1'b1, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      // Window of zero behaves as one: output equals input, any address allowed
      '{ROW_WINDOW, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'h0000, 8'h12, 8'h34, 8'h56, 1'b0, 4'd0, 1'b1, 8'h12, 8'h34, 8'h56},
      '{ROW_PIXEL,  16'h1357, 8'hFE, 8'h01, 8'h80, 1'b0, 4'd0, 1'b1, 8'hFE, 8'h01, 8'h80},
      '{ROW_PIXEL,  16'hFFFF, 8'h9A, 8'hBC, 8'hDE, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'h5555, 8'h00, 8'hFF, 8'h00, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'hAAAA, 8'hFF, 8'h00, 8'hFF, 1'b1, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      // Window changed mid-frame, and above the maximum it clamps to the maximum
      '{ROW_PIXEL,  16'h0000, 8'h66, 8'h77, 8'h88, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_WINDOW, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 4'd15, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'hFFFF, 8'h01, 8'h02, 8'h03, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'h5555, 8'hFD, 8'hFE, 8'hFF, 1'b0, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_PIXEL,  16'hAAAA, 8'h5A, 8'hA5, 8'h3C, 1'b1, 4'd0, 1'b0, 8'h00, 8'h00, 8'h00},
      '{ROW_WINDOW, 16'h0000, 8'h00, 8'h00, 8'h00, 1'b0, 4'd8, 1'b0, 8'h00, 8'h00, 8'h00}
   };

   // DUT connections, all known from time zero
   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              csr_psel       = 1'b0;
   logic              csr_penable    = 1'b0;
   logic              csr_pwrite     = 1'b0;
   logic [CSR_AW-1:0] csr_paddr      = '0;
   logic [CSR_DW-1:0] csr_pwdata     = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   logic              req_valid      = 1'b0;
   logic              req_stall;
   logic [ADDR_W-1:0] req_pixel_addr = '0;
   logic [CHAN_W-1:0] req_chan0      = '0;
   logic [CHAN_W-1:0] req_chan1      = '0;
   logic [CHAN_W-1:0] req_chan2      = '0;
   logic              req_frame_end  = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic [CHAN_W-1:0] rsp_mean0;
   logic [CHAN_W-1:0] rsp_mean1;
   logic [CHAN_W-1:0] rsp_mean2;
   logic              rsp_frame_done;

   // Predictor state: ring image keyed by {slot, address}, each entry tagged with the
   // number of the frame that wrote it, so a slot reused by a later frame reads as unwritten
   typedef logic [SLOT_W+ADDR_W-1:0] ring_key_type;
   logic [PIX_W-1:0]  ring_img [ring_key_type];
   int unsigned       ring_tag [ring_key_type];
   logic [WIN_W-1:0]  window_reg  = WINDOW_RESET;
   int unsigned       frames_done = 0;
   int unsigned       frame_no    = 0;
   logic [SLOT_W-1:0] slot_now    = '0;

   mean_type mean_q [$];          // expected means, oldest first
   mean_type pending_mean = '0;   // expectation travelling with the item on req_
   int    send_idle    = 38;   // percent chance of a sender gap per cycle
   int    recv_idle    = 48;   // percent chance of a receiver stall per cycle
   int    fail_count   = 0;
   int    cycle_count  = 0;

   temporal_frame_mean_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_addr (req_pixel_addr),
      .req_chan0      (req_chan0),
      .req_chan1      (req_chan1),
      .req_chan2      (req_chan2),
      .req_frame_end  (req_frame_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_mean0      (rsp_mean0),
      .rsp_mean1      (rsp_mean1),
      .rsp_mean2      (rsp_mean2),
      .rsp_frame_done (rsp_frame_done)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_stall <= (recv_idle != 0) && ($urandom_range(99) < recv_idle);
   end

   // ---------------------------------------------------------------- predictor

   // Divide and round to nearest, ties to even
   function automatic logic [CHAN_W-1:0] round_half_even(int unsigned sum, int unsigned n);
      int unsigned q;
      int unsigned r;
      q = sum / n;
      r = sum % n;
      if ((2 * r > n) || ((2 * r == n) && q[0]))
         q++;
      return CHAN_W'(q);
   endfunction

   // Frames averaged for the next pixel: the window clamped to 1..MAX_WINDOW,
   // limited by how many frames have been seen so far
   function automatic int unsigned frames_in_mean();
      int unsigned w;
      int unsigned n;
      w = window_reg;
      if (w < 1)
         w = 1;
      if (w > MAX_WINDOW)
         w = MAX_WINDOW;
      n = frames_done + 1;
      return (n > w) ? w : n;
   endfunction

   function automatic logic [SLOT_W-1:0] slot_back(int unsigned k);
      return SLOT_W'((int'(slot_now) + MAX_WINDOW - int'(k)) % MAX_WINDOW);
   endfunction

   // True when the frame k back wrote this address
   function automatic bit entry_written(int unsigned k, logic [ADDR_W-1:0] a);
      ring_key_type key;
      key = {slot_back(k), a};
      return ring_tag.exists(key) && (ring_tag[key] == frame_no - k);
   endfunction

   // True when every older frame in the mean holds this address
   function automatic bit addr_readable(logic [ADDR_W-1:0] a);
      int unsigned n;
      n = frames_in_mean();
      for (int unsigned k = 1; k < n; k++)
         if (!entry_written(k, a))
            return 1'b0;
      return 1'b1;
   endfunction

   // Store the pixel in the current slot, average over the frames in the mean,
   // then move to the next slot on an end-of-frame mark
   function automatic mean_type predict_mean(pixel_type p);
      int unsigned      n;
      int unsigned      s0;
      int unsigned      s1;
      int unsigned      s2;
      logic [PIX_W-1:0] e;
      ring_key_type     key;
      mean_type         m;
      n  = frames_in_mean();
      s0 = 0;
      s1 = 0;
      s2 = 0;
      ring_img[{slot_now, p.pixel_addr}] = {p.chan2, p.chan1, p.chan0};
      ring_tag[{slot_now, p.pixel_addr}] = frame_no;
      for (int unsigned k = 0; k < n; k++) begin
         key = {slot_back(k), p.pixel_addr};
         e   = entry_written(k, p.pixel_addr) ? ring_img[key] : '0;
         s0 += e[CHAN_W-1:0];
         s1 += e[2*CHAN_W-1:CHAN_W];
         s2 += e[3*CHAN_W-1:2*CHAN_W];
      end
      m.mean0      = round_half_even(s0, n);
      m.mean1      = round_half_even(s1, n);
      m.mean2      = round_half_even(s2, n);
      m.frame_done = p.frame_end;
      if (p.frame_end) begin
         slot_now = SLOT_W'((int'(slot_now) + 1) % MAX_WINDOW);
         frame_no++;
         if (frames_done < MAX_WINDOW)
            frames_done++;
      end
      return m;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Present one item, with random sender gaps ahead of it, and return at the
   // edge that accepts it. valid stays high so the next item can follow at once.
   task automatic send_pixel(pixel_type p, mean_type want);
      while ((send_idle != 0) && ($urandom_range(99) < send_idle)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_pixel_addr <= p.pixel_addr;
      req_chan0      <= p.chan0;
      req_chan1      <= p.chan1;
      req_chan2      <= p.chan2;
      req_frame_end  <= p.frame_end;
      pending_mean   <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending and wait until every expected mean has come back.
   // The first edge lets the monitor queue the last accepted item.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (mean_q.size() != 0)
         @(posedge clock);
   endtask

   // One APB transfer: setup, access until pready, then back to idle
   task automatic csr_access(input bit wr, input logic [CSR_AW-1:0] a,
                             input logic [CSR_DW-1:0] d, output logic [CSR_DW-1:0] rd);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= a;
      csr_pwdata  <= d;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Window writes happen only with the pipeline empty; the value is read back
   task automatic set_window(logic [WIN_W-1:0] val);
      logic [CSR_DW-1:0] rd;
      wait_drained();
      csr_access(1'b1, WINDOW_LENGTH_ADDR, CSR_DW'(val), rd);
      csr_access(1'b0, WINDOW_LENGTH_ADDR, '0, rd);
      if (rd !== CSR_DW'(val)) begin
         $error("window_length readback: expected %0h, actual %0h", val, rd);
         fail_count++;
      end
      window_reg = val;
   endtask

   // Channel sample, biased towards the extremes
   function automatic logic [CHAN_W-1:0] rand_chan();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   // One well-formed frame: every pool address in random order, plus noise items
   // (repeats and stray addresses that older frames are known to hold)
   task automatic send_frame(output int n_items);
      pixel_type         fq [$];
      pixel_type         tmp;
      logic [ADDR_W-1:0] a;
      int                j;
      tmp = '0;
      foreach (POOL_ADDR[i]) begin
         tmp.pixel_addr = POOL_ADDR[i];
         fq.insert(fq.size(), tmp);
      end
      repeat ($urandom_range(4)) begin
         a = ($urandom_range(1) == 1) ? ADDR_W'($urandom) : POOL_ADDR[$urandom_range(3)];
         if (!addr_readable(a))
            a = POOL_ADDR[$urandom_range(3)];
         tmp.pixel_addr = a;
         fq.insert(fq.size(), tmp);
      end
      for (int i = fq.size() - 1; i > 0; i--) begin
         j     = $urandom_range(i);
         tmp   = fq[i];
         fq[i] = fq[j];
         fq[j] = tmp;
      end
      foreach (fq[i]) begin
         fq[i].chan0     = rand_chan();
         fq[i].chan1     = rand_chan();
         fq[i].chan2     = rand_chan();
         fq[i].frame_end = (i == fq.size() - 1);
         send_pixel(fq[i], predict_mean(fq[i]));
      end
      n_items = fq.size();
   endtask

   // ---------------------------------------------------------------- checker

   // Queue the expectation of each accepted item, compare each accepted result
   always @(posedge clock) begin : mean_check
      mean_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            mean_q.insert(mean_q.size(), pending_mean);
         if (rsp_valid && !rsp_stall) begin
            if (mean_q.size() == 0) begin
               $error("result item with no expected mean waiting");
               fail_count++;
            end else begin
               want = mean_q[0];
               mean_q.delete(0);
               if (rsp_mean0 !== want.mean0) begin
                  $error("mean0: expected %0h, actual %0h", want.mean0, rsp_mean0);
                  fail_count++;
               end
               if (rsp_mean1 !== want.mean1) begin
                  $error("mean1: expected %0h, actual %0h", want.mean1, rsp_mean1);
                  fail_count++;
               end
               if (rsp_mean2 !== want.mean2) begin
                  $error("mean2: expected %0h, actual %0h", want.mean2, rsp_mean2);
                  fail_count++;
               end
               if (rsp_frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0h, actual %0h",
                         want.frame_done, rsp_frame_done);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** temporal_frame_mean_top: FAILED **");
      $finish;
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      pixel_type p;
      mean_type  pred;
      mean_type  typed;
      int        n;
      int        block_items;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows, run under the first idling mix
      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].kind == ROW_WINDOW) begin
            set_window(DIR_ROWS[i].window);
         end else begin
            p     = '{DIR_ROWS[i].pixel_addr, DIR_ROWS[i].chan0, DIR_ROWS[i].chan1,
                      DIR_ROWS[i].chan2, DIR_ROWS[i].frame_end};
            typed = '{DIR_ROWS[i].mean0, DIR_ROWS[i].mean1, DIR_ROWS[i].mean2,
                      DIR_ROWS[i].frame_end};
            pred  = predict_mean(p);
            send_pixel(p, DIR_ROWS[i].known_mean ? typed : pred);
         end
      end

      // Random frames: three idling mixes, four window settings in each.
      // Each window write drains the pipeline first, so the sender pauses
      // until every expected mean has come back.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 38;
               recv_idle = 48;
            end
            1: begin
               send_idle = 48;
               recv_idle = 38;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         for (int blk = 0; blk < 4; blk++) begin
            set_window(WINDOW_PLAN[phase * 4 + blk]);
            block_items = 0;
            while (block_items < BLOCK_ITEMS) begin
               send_frame(n);
               block_items += n;
            end
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("** temporal_frame_mean_top: PASSED **");
      else
         $display("** temporal_frame_mean_top: FAILED **");
      $finish;
   end

endmodule
